@@ rtl/core/adlif_pkg.sv @@
// Shared types, constants, control-word encoding and microcode ROM for the adaptive LIF neuron.
package adlif_pkg;

    localparam int VALUE_BITS = 32;
    localparam int OUT_W      = 32;
    localparam int FACT_W     = 31;
    localparam int PROP_W     = 17;
    localparam int REFR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MUL_W      = VALUE_BITS + FACT_W + 1;
    localparam int PROD_W     = MUL_W - FRAC_BITS;
    localparam int ACC_W      = PROD_W + 2;
    localparam int STEP_W     = 3;

    localparam logic signed [ACC_W-1:0] FIX_ONE = ACC_W'(65536);
    localparam logic signed [ACC_W-1:0] VAL_MAX =
        ACC_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] VAL_MIN = -VAL_MAX - ACC_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_MEMBRANE_DECAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_DECAY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_STRENGTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_FLOOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_STEPS = 3'd7;

    localparam logic [PROP_W-1:0]            RST_MEMBRANE_DECAY   = 17'd59299;
    localparam logic [FACT_W-1:0]            RST_CURRENT_GAIN     = 31'd262;
    localparam logic [PROP_W-1:0]            RST_SPIKE_GAIN       = 17'd65536;
    localparam logic [PROP_W-1:0]            RST_ADAPT_DECAY      = 17'd59299;
    localparam logic signed [VALUE_BITS-1:0] RST_BASE_THRESHOLD   = VALUE_BITS'(983040);
    localparam logic [FACT_W-1:0]            RST_ADAPT_STRENGTH   = 31'd65536;
    localparam logic signed [VALUE_BITS-1:0] RST_VOLTAGE_FLOOR    = VALUE_BITS'(VAL_MIN);
    localparam logic [REFR_W-1:0]            RST_REFRACTORY_STEPS = 16'd20;

    localparam logic [1:0] MA_ADAPT = 2'd0;
    localparam logic [1:0] MA_PREV  = 2'd1;
    localparam logic [1:0] MA_SPIKE = 2'd2;
    localparam logic [1:0] MA_VOLT  = 2'd3;

    localparam logic [2:0] MB_ADECAY = 3'd0;
    localparam logic [2:0] MB_CGAIN  = 3'd1;
    localparam logic [2:0] MB_SGAIN  = 3'd2;
    localparam logic [2:0] MB_MDECAY = 3'd3;
    localparam logic [2:0] MB_ASTR   = 3'd4;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    localparam logic [1:0] BIAS_NONE     = 2'd0;
    localparam logic [1:0] BIAS_NEG_BASE = 2'd1;
    localparam logic [1:0] BIAS_ONE      = 2'd2;
    localparam logic [1:0] BIAS_BASE     = 2'd3;

    localparam logic [1:0] WB_NONE   = 2'd0;
    localparam logic [1:0] WB_ADAPT  = 2'd1;
    localparam logic [1:0] WB_VOLT   = 2'd2;
    localparam logic [1:0] WB_THRESH = 2'd3;

    localparam logic [1:0] HC_NONE     = 2'd0;
    localparam logic [1:0] HC_IN_IDLE  = 2'd1;
    localparam logic [1:0] HC_OUT_BUSY = 2'd2;

    localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;

    typedef struct packed {
        logic [1:0]        mul_a;
        logic [2:0]        mul_b;
        logic              mul_en;
        logic [1:0]        acc_op;
        logic [1:0]        bias;
        logic [1:0]        wb;
        logic              capture;
        logic              finish;
        logic [1:0]        hold;
        logic              jump;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '{mul_a: MA_ADAPT, mul_b: MB_ADECAY, mul_en: 1'b0, acc_op: ACC_HOLD,
              bias: BIAS_NONE, wb: WB_NONE, capture: 1'b0, finish: 1'b0,
              hold: HC_NONE, jump: 1'b0, target: STEP_IDLE};
        case (step)
            3'd0: begin
                c.capture = 1'b1;
                c.hold    = HC_IN_IDLE;
            end
            3'd1: begin
                c.mul_a  = MA_ADAPT;
                c.mul_b  = MB_ADECAY;
                c.mul_en = 1'b1;
            end
            3'd2: begin
                c.mul_a  = MA_PREV;
                c.mul_b  = MB_CGAIN;
                c.mul_en = 1'b1;
                c.acc_op = ACC_LOAD;
                c.bias   = BIAS_ONE;
            end
            3'd3: begin
                c.mul_a  = MA_SPIKE;
                c.mul_b  = MB_SGAIN;
                c.mul_en = 1'b1;
                c.acc_op = ACC_LOAD;
                c.wb     = WB_ADAPT;
            end
            3'd4: begin
                c.mul_a  = MA_VOLT;
                c.mul_b  = MB_MDECAY;
                c.mul_en = 1'b1;
                c.acc_op = ACC_ADD;
            end
            3'd5: begin
                c.mul_a  = MA_ADAPT;
                c.mul_b  = MB_ASTR;
                c.mul_en = 1'b1;
                c.acc_op = ACC_ADD;
                c.bias   = BIAS_NEG_BASE;
            end
            3'd6: begin
                c.acc_op = ACC_LOAD;
                c.bias   = BIAS_BASE;
                c.wb     = WB_VOLT;
            end
            3'd7: begin
                c.wb     = WB_THRESH;
                c.finish = 1'b1;
                c.hold   = HC_OUT_BUSY;
                c.jump   = 1'b1;
                c.target = STEP_IDLE;
            end
            default: begin
                c.jump   = 1'b1;
                c.target = STEP_IDLE;
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] sat_value(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] s;
        s = v;
        if (v > VAL_MAX) begin
            s = VAL_MAX;
        end else if (v < VAL_MIN) begin
            s = VAL_MIN;
        end
        return s[VALUE_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/adaptive_lif_neuron_step.sv @@
// Result valid is registered when the eight-step microprogram finishes; the program
// shares one multiplier and one accumulator across all five products.
// A new input is not taken until the previous one is through; a stalled result holds the
// final microstep and the next input transaction is taken as soon as the program returns idle.
// Reset: synchronous active-low; clears state, loads register defaults, no clearing pass.
// Top level: adaptive LIF neuron time-step engine, sequencer plus datapath.
module adaptive_lif_neuron_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [adlif_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [adlif_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [adlif_pkg::OUT_W-1:0]  i_spike_input,
    input  logic signed [adlif_pkg::OUT_W-1:0]  i_current_input,
    input  logic                                i_reset_now,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_spike_out,
    output logic signed [adlif_pkg::OUT_W-1:0]  o_membrane_voltage,
    output logic signed [adlif_pkg::OUT_W-1:0]  o_threshold_now,
    output logic signed [adlif_pkg::OUT_W-1:0]  o_adaptation_level
);
    import adlif_pkg::*;

    t_ctrl w_ctrl;
    logic  w_go;
    logic  w_out_busy;

    adlif_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (w_out_busy),
        .o_ctrl     (w_ctrl),
        .o_go       (w_go)
    );

    adlif_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (w_ctrl),
        .i_go               (w_go),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_spike_input      (i_spike_input),
        .i_current_input    (i_current_input),
        .i_reset_now        (i_reset_now),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_out_busy         (w_out_busy),
        .o_spike_out        (o_spike_out),
        .o_membrane_voltage (o_membrane_voltage),
        .o_threshold_now    (o_threshold_now),
        .o_adaptation_level (o_adaptation_level)
    );

    assign o_in_stall = ~w_ctrl.capture;

endmodule

@@ rtl/core/adlif_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup, hold and jump logic.
module adlif_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    output adlif_pkg::t_ctrl o_ctrl,
    output logic            o_go
);
    import adlif_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_ctrl;
    logic              w_hold;

    assign w_ctrl = ucode(r_step);

    always_comb begin
        case (w_ctrl.hold)
            HC_NONE:     w_hold = 1'b0;
            HC_IN_IDLE:  w_hold = ~i_in_valid;
            HC_OUT_BUSY: w_hold = i_out_busy;
            default:     w_hold = 1'b0;
        endcase
    end

    always_comb begin
        if (w_hold) begin
            n_step = r_step;
        end else if (w_ctrl.jump) begin
            n_step = w_ctrl.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_go   = ~w_hold;

endmodule

@@ rtl/core/adlif_dp.sv @@
// Datapath: configuration registers, neuron state, shared multiplier, accumulator, result register.
module adlif_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  adlif_pkg::t_ctrl                        i_ctrl,
    input  logic                                    i_go,
    input  logic                                    i_cfg_we,
    input  logic [adlif_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [adlif_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic signed [adlif_pkg::OUT_W-1:0]      i_spike_input,
    input  logic signed [adlif_pkg::OUT_W-1:0]      i_current_input,
    input  logic                                    i_reset_now,
    input  logic                                    i_out_stall,
    output logic                                    o_out_valid,
    output logic                                    o_out_busy,
    output logic                                    o_spike_out,
    output logic signed [adlif_pkg::OUT_W-1:0]      o_membrane_voltage,
    output logic signed [adlif_pkg::OUT_W-1:0]      o_threshold_now,
    output logic signed [adlif_pkg::OUT_W-1:0]      o_adaptation_level
);
    import adlif_pkg::*;

    logic [PROP_W-1:0]            r_mdecay;
    logic [FACT_W-1:0]            r_cgain;
    logic [PROP_W-1:0]            r_sgain;
    logic [PROP_W-1:0]            r_adecay;
    logic signed [VALUE_BITS-1:0] r_base;
    logic [FACT_W-1:0]            r_astr;
    logic signed [VALUE_BITS-1:0] r_floor;
    logic [REFR_W-1:0]            r_refr_steps;

    logic signed [VALUE_BITS-1:0] r_volt;
    logic signed [VALUE_BITS-1:0] r_adapt;
    logic [REFR_W-1:0]            r_refr;
    logic                         r_spk;
    logic signed [VALUE_BITS-1:0] r_prev;
    logic signed [VALUE_BITS-1:0] r_z;
    logic signed [VALUE_BITS-1:0] r_cur;

    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      n_acc;

    logic                         r_out_valid;
    logic                         r_out_spk;
    logic signed [OUT_W-1:0]      r_out_volt;
    logic signed [OUT_W-1:0]      r_out_thresh;
    logic signed [OUT_W-1:0]      r_out_adapt;

    logic signed [VALUE_BITS-1:0] w_mul_a;
    logic [FACT_W-1:0]            w_mul_b;
    logic signed [FACT_W:0]       w_mul_b_s;
    logic signed [MUL_W-1:0]      w_mul_full;
    logic signed [ACC_W-1:0]      w_bias;
    logic signed [ACC_W-1:0]      w_base_ext;
    logic signed [ACC_W-1:0]      w_floor_ext;
    logic signed [ACC_W-1:0]      w_clamped;
    logic signed [VALUE_BITS-1:0] w_thresh;
    logic                         w_fire;
    logic                         w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mdecay     <= RST_MEMBRANE_DECAY;
            r_cgain      <= RST_CURRENT_GAIN;
            r_sgain      <= RST_SPIKE_GAIN;
            r_adecay     <= RST_ADAPT_DECAY;
            r_base       <= RST_BASE_THRESHOLD;
            r_astr       <= RST_ADAPT_STRENGTH;
            r_floor      <= RST_VOLTAGE_FLOOR;
            r_refr_steps <= RST_REFRACTORY_STEPS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MEMBRANE_DECAY:   r_mdecay     <= i_cfg_data[PROP_W-1:0];
                REG_CURRENT_GAIN:     r_cgain      <= i_cfg_data[FACT_W-1:0];
                REG_SPIKE_GAIN:       r_sgain      <= i_cfg_data[PROP_W-1:0];
                REG_ADAPT_DECAY:      r_adecay     <= i_cfg_data[PROP_W-1:0];
                REG_BASE_THRESHOLD:   r_base       <= VALUE_BITS'($signed(i_cfg_data));
                REG_ADAPT_STRENGTH:   r_astr       <= i_cfg_data[FACT_W-1:0];
                REG_VOLTAGE_FLOOR:    r_floor      <= VALUE_BITS'($signed(i_cfg_data));
                REG_REFRACTORY_STEPS: r_refr_steps <= i_cfg_data[REFR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_ctrl.mul_a)
            MA_ADAPT: w_mul_a = r_adapt;
            MA_PREV:  w_mul_a = r_prev;
            MA_SPIKE: w_mul_a = r_z;
            MA_VOLT:  w_mul_a = r_volt;
            default:  w_mul_a = r_adapt;
        endcase
        case (i_ctrl.mul_b)
            MB_ADECAY: w_mul_b = FACT_W'(r_adecay);
            MB_CGAIN:  w_mul_b = r_cgain;
            MB_SGAIN:  w_mul_b = FACT_W'(r_sgain);
            MB_MDECAY: w_mul_b = FACT_W'(r_mdecay);
            MB_ASTR:   w_mul_b = r_astr;
            default:   w_mul_b = '0;
        endcase
    end

    assign w_mul_b_s  = $signed({1'b0, w_mul_b});
    assign w_mul_full = w_mul_a * w_mul_b_s;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= w_mul_full[MUL_W-1:FRAC_BITS];
        end
    end

    assign w_base_ext  = ACC_W'(r_base);
    assign w_floor_ext = ACC_W'(r_floor);

    always_comb begin
        case (i_ctrl.bias)
            BIAS_NONE:     w_bias = '0;
            BIAS_NEG_BASE: w_bias = r_spk ? -w_base_ext : '0;
            BIAS_ONE:      w_bias = r_spk ? FIX_ONE : '0;
            BIAS_BASE:     w_bias = w_base_ext;
            default:       w_bias = '0;
        endcase
        case (i_ctrl.acc_op)
            ACC_HOLD: n_acc = r_acc;
            ACC_LOAD: n_acc = ACC_W'(r_prod) + w_bias;
            ACC_ADD:  n_acc = r_acc + ACC_W'(r_prod) + w_bias;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign w_clamped = (r_acc < w_floor_ext) ? w_floor_ext : r_acc;
    assign w_thresh  = sat_value(r_acc);
    assign w_fire    = (r_volt >= w_thresh) && (r_refr == '0);
    assign w_wr      = i_go && i_ctrl.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt  <= '0;
            r_adapt <= '0;
            r_refr  <= '0;
            r_spk   <= 1'b0;
            r_prev  <= '0;
        end else begin
            if (i_go && i_ctrl.capture) begin
                if (i_reset_now) begin
                    r_volt  <= '0;
                    r_adapt <= '0;
                    r_refr  <= '0;
                    r_spk   <= 1'b0;
                end else if (r_refr != '0) begin
                    r_refr <= r_refr - REFR_W'(1);
                end
            end
            if (i_ctrl.wb == WB_ADAPT) begin
                r_adapt <= sat_value(r_acc);
            end
            if (i_ctrl.wb == WB_VOLT) begin
                r_volt <= sat_value(w_clamped);
            end
            if (w_wr) begin
                r_spk  <= w_fire;
                r_prev <= r_cur;
                if (w_fire) begin
                    r_refr <= r_refr_steps;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_ctrl.capture) begin
            r_z   <= VALUE_BITS'(i_spike_input);
            r_cur <= VALUE_BITS'(i_current_input);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_out_spk    <= w_fire;
            r_out_volt   <= OUT_W'(r_volt);
            r_out_thresh <= OUT_W'(w_thresh);
            r_out_adapt  <= OUT_W'(r_adapt);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_busy         = r_out_valid & i_out_stall;
    assign o_spike_out        = r_out_spk;
    assign o_membrane_voltage = r_out_volt;
    assign o_threshold_now    = r_out_thresh;
    assign o_adaptation_level = r_out_adapt;

endmodule
